[rtl/core/streaming_top_k_select_unit_defines.svh]
// assertion macros used by the checker file stks_checker
`ifndef STREAMING_TOP_K_SELECT_UNIT_DEFINES_SVH
`define STREAMING_TOP_K_SELECT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define STKS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top-k select check failed");

// next-cycle implication, disabled while reset is asserted
`define STKS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top-k select check failed");

`endif

[rtl/core/stks_pkg.sv]
`default_nettype none

package stks_pkg;

    // field widths of the item and result
    localparam int WEIGHT_W = 32;
    localparam int TAG_W    = 20;
    localparam int RANK_W   = 7;

    // defaults for the top-level parameters
    localparam int KEEP_COUNT_DEF = 100;
    localparam int TAG_BITS_DEF   = 20;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the new item
        logic rot;   // rotate the whole list by one place
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/core/stks_cell.sv]
`default_nettype none

module stks_cell #(
    parameter int TAG_BITS = stks_pkg::TAG_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stks_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [stks_pkg::WEIGHT_W-1:0] i_new_weight,
    input  logic [TAG_BITS-1:0]                 i_new_tag,
    input  logic                                i_up_le,
    input  logic signed [stks_pkg::WEIGHT_W-1:0] i_up_weight,
    input  logic [TAG_BITS-1:0]                 i_up_tag,
    input  logic signed [stks_pkg::WEIGHT_W-1:0] i_rot_weight,
    input  logic [TAG_BITS-1:0]                 i_rot_tag,
    output logic                                o_le,
    output logic signed [stks_pkg::WEIGHT_W-1:0] o_weight,
    output logic [TAG_BITS-1:0]                 o_tag
);
    import stks_pkg::*;

    logic signed [WEIGHT_W-1:0] r_weight, n_weight;
    logic [TAG_BITS-1:0]        r_tag, n_tag;
    logic                       le;

    // kept weight not above the incoming one
    assign le = (r_weight <= i_new_weight);

    always_comb begin
        n_weight = r_weight;
        n_tag    = r_tag;
        if (i_ctrl.rot) begin
            n_weight = i_rot_weight;
            n_tag    = i_rot_tag;
        end else if (i_ctrl.ins) begin
            if (i_up_le) begin
                // heavier neighbour also moves down
                n_weight = i_up_weight;
                n_tag    = i_up_tag;
            end else if (le) begin
                // new item lands here, above equal weights
                n_weight = i_new_weight;
                n_tag    = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
            r_tag    <= '0;
        end else begin
            r_weight <= n_weight;
            r_tag    <= n_tag;
        end
    end

    assign o_le     = le;
    assign o_weight = r_weight;
    assign o_tag    = r_tag;

endmodule

`default_nettype wire

[rtl/core/streaming_top_k_select_unit.sv]
// channel   | signals                                             | direction
// ----------+-----------------------------------------------------+----------
// command   | i_start, o_busy, i_op, i_new_weight, i_new_tag, i_rank | in
// result    | o_valid, o_out_weight, o_out_tag                    | out
//
// an insert leaves o_busy low, so inserts can follow every cycle while no read is running
// a read holds o_busy while the whole list rotates once round the chain
// the result of a read at rank r is registered as that entry reaches the heaviest slot, high for one cycle
// synchronous active-low reset clears every slot to weight 0, tag 0
// the receiver cannot stall: o_valid is a one-cycle strobe
`default_nettype none

module streaming_top_k_select_unit #(
    parameter int KEEP_COUNT = stks_pkg::KEEP_COUNT_DEF,
    parameter int TAG_BITS   = stks_pkg::TAG_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_op,
    input  logic signed [stks_pkg::WEIGHT_W-1:0] i_new_weight,
    input  logic [stks_pkg::TAG_W-1:0]           i_new_tag,
    input  logic [stks_pkg::RANK_W-1:0]          i_rank,
    output logic                                 o_valid,
    output logic signed [stks_pkg::WEIGHT_W-1:0] o_out_weight,
    output logic [stks_pkg::TAG_W-1:0]           o_out_tag
);
    import stks_pkg::*;

    // rotation counter runs over every slot of the chain
    localparam int CNT_W = $clog2(KEEP_COUNT);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_rank, n_rank;
    logic             r_valid, n_valid;
    logic signed [WEIGHT_W-1:0] r_out_weight, n_out_weight;
    logic [TAG_W-1:0]           r_out_tag, n_out_tag;

    logic             accept;
    logic [CNT_W-1:0] rank_sat;
    logic [TAG_BITS-1:0] tag_in;
    t_cell_ctrl       ctrl;

    // chain wiring, slot 0 lightest, slot KEEP_COUNT-1 heaviest
    logic signed [WEIGHT_W-1:0] w_weight [KEEP_COUNT];
    logic [TAG_BITS-1:0]        w_tag    [KEEP_COUNT];
    logic                       w_le     [KEEP_COUNT];

    assign accept = i_start && (r_state == ST_IDLE);

    // tag kept to TAG_BITS bits
    assign tag_in = TAG_BITS'(i_new_tag);

    // ranks past the list read the lightest entry
    assign rank_sat = (32'(i_rank) >= KEEP_COUNT) ? CNT_W'(KEEP_COUNT - 1)
                                                  : CNT_W'(i_rank);

    assign ctrl.ins = accept && (i_op == OP_INSERT);
    assign ctrl.rot = (r_state == ST_READ);

    genvar gi;
    generate
        for (gi = 0; gi < KEEP_COUNT; gi++) begin : g_cell
            logic                       up_le;
            logic signed [WEIGHT_W-1:0] up_weight;
            logic [TAG_BITS-1:0]        up_tag;
            logic signed [WEIGHT_W-1:0] rot_weight;
            logic [TAG_BITS-1:0]        rot_tag;

            // heaviest cell has nothing above it
            if (gi == KEEP_COUNT - 1) begin : g_top
                assign up_le     = 1'b0;
                assign up_weight = w_weight[gi];
                assign up_tag    = w_tag[gi];
            end else begin : g_mid
                assign up_le     = w_le[gi + 1];
                assign up_weight = w_weight[gi + 1];
                assign up_tag    = w_tag[gi + 1];
            end

            // rotation wraps the heaviest end back to the lightest
            if (gi == 0) begin : g_wrap
                assign rot_weight = w_weight[KEEP_COUNT - 1];
                assign rot_tag    = w_tag[KEEP_COUNT - 1];
            end else begin : g_link
                assign rot_weight = w_weight[gi - 1];
                assign rot_tag    = w_tag[gi - 1];
            end

            stks_cell #(
                .TAG_BITS(TAG_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (ctrl),
                .i_new_weight(i_new_weight),
                .i_new_tag   (tag_in),
                .i_up_le     (up_le),
                .i_up_weight (up_weight),
                .i_up_tag    (up_tag),
                .i_rot_weight(rot_weight),
                .i_rot_tag   (rot_tag),
                .o_le        (w_le[gi]),
                .o_weight    (w_weight[gi]),
                .o_tag       (w_tag[gi])
            );
        end
    endgenerate

    // read sequencer: after r_cnt rotations the heaviest cell holds the entry of rank r_cnt
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rank       = r_rank;
        n_valid      = 1'b0;
        n_out_weight = r_out_weight;
        n_out_tag    = r_out_tag;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_op == OP_READ)) begin
                    n_state = ST_READ;
                    n_cnt   = '0;
                    n_rank  = rank_sat;
                end
            end
            ST_READ: begin
                if (r_cnt == r_rank) begin
                    n_valid      = 1'b1;
                    n_out_weight = w_weight[KEEP_COUNT - 1];
                    n_out_tag    = TAG_W'(64'(w_tag[KEEP_COUNT - 1]));
                end
                // full turn restores the list order
                if (r_cnt == CNT_W'(KEEP_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
                n_cnt = r_cnt + 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_rank       <= n_rank;
        r_out_weight <= n_out_weight;
        r_out_tag    <= n_out_tag;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_out_weight = r_out_weight;
    assign o_out_tag    = r_out_tag;

endmodule

`default_nettype wire

[rtl/core/stks_checker.sv]
`default_nettype none
`include "streaming_top_k_select_unit_defines.svh"

module stks_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic                                 o_busy,
    input  wire logic                                 i_op,
    input  wire logic signed [stks_pkg::WEIGHT_W-1:0] i_new_weight,
    input  wire logic [stks_pkg::TAG_W-1:0]           i_new_tag,
    input  wire logic [stks_pkg::RANK_W-1:0]          i_rank,
    input  wire logic                                 o_valid,
    input  wire logic signed [stks_pkg::WEIGHT_W-1:0] o_out_weight,
    input  wire logic [stks_pkg::TAG_W-1:0]           o_out_tag
);
    import stks_pkg::*;

    logic rd_xfer;
    logic ins_xfer;

    assign rd_xfer  = i_start && !o_busy && (i_op == OP_READ);
    assign ins_xfer = i_start && !o_busy && (i_op == OP_INSERT);

    // a result only follows a cycle of read work
    `STKS_ASSERT_SAME(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(o_busy))

    // a read transfer starts the rotation
    `STKS_ASSERT_NEXT(a_read_goes_busy, i_clk, i_rst_n, rd_xfer, o_busy)

    // an insert finishes in its own cycle
    `STKS_ASSERT_NEXT(a_insert_stays_idle, i_clk, i_rst_n, ins_xfer, !o_busy)

    // heaviest entry comes out after its read transfer, through the first read state and the result register
    `STKS_ASSERT_SAME(a_rank0_latency, i_clk, i_rst_n, $past(rd_xfer && (i_rank == '0), 2), o_valid)

endmodule

bind streaming_top_k_select_unit stks_checker u_stks_checker (.*);

`default_nettype wire

[test/stks_rank_checker.sv]
module stks_rank_checker
    import stks_pkg::*;
#(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_op,
    input  logic signed [WEIGHT_W-1:0]  i_new_weight,
    input  logic [TAG_W-1:0]            i_new_tag,
    input  logic [RANK_W-1:0]           i_rank,
    input  logic                        i_valid,
    input  logic signed [WEIGHT_W-1:0]  i_out_weight,
    input  logic [TAG_W-1:0]            i_out_tag,
    output int                          o_mismatch_count,
    output int                          o_reads_due
);

    localparam logic [TAG_W-1:0] TAG_MASK =
        (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [TAG_W-1:0]           tag;
    } t_entry;

    // kept list in rank order, index 0 heaviest
    t_entry ranked [KEEP_COUNT];
    t_entry entries_due [$];
    int     mismatch_count = 0;
    int     due_depth = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_reads_due      = due_depth;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // new item lands above every kept entry of equal weight
    function automatic void admit_item(input logic signed [WEIGHT_W-1:0] w,
                                       input logic [TAG_W-1:0] t);
        int     slot;
        t_entry fresh;
        if (w < ranked[KEEP_COUNT-1].weight) begin
            return;
        end
        slot = 0;
        while (ranked[slot].weight > w) begin
            slot++;
        end
        for (int i = KEEP_COUNT - 1; i > slot; i--) begin
            ranked[i] = ranked[i-1];
        end
        fresh.weight = w;
        fresh.tag    = t & TAG_MASK;
        ranked[slot] = fresh;
    endfunction

    always @(posedge i_clk) begin
        t_entry due;
        int     idx;
        if (!i_rst_n) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                ranked[i] = '0;
            end
            entries_due.delete();
        end else begin
            if (i_valid) begin
                if (entries_due.size() == 0) begin
                    report_mismatch($sformatf("result with no read outstanding (w=%0d tag=%h)",
                                              i_out_weight, i_out_tag));
                end else begin
                    due = entries_due.pop_front();
                    if (i_out_weight !== due.weight) begin
                        report_mismatch($sformatf("weight got %0d, want %0d",
                                                  i_out_weight, due.weight));
                    end
                    if (i_out_tag !== due.tag) begin
                        report_mismatch($sformatf("tag got %h, want %h", i_out_tag, due.tag));
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_op == OP_INSERT) begin
                    admit_item(i_new_weight, i_new_tag);
                end else begin
                    // ranks past the end read the lightest entry
                    idx = (int'(i_rank) >= KEEP_COUNT) ? KEEP_COUNT - 1 : int'(i_rank);
                    entries_due.push_back(ranked[idx]);
                end
            end
        end
        due_depth <= entries_due.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    import stks_pkg::*;

    localparam int KEEP        = KEEP_COUNT_DEF;
    localparam int ITEM_COUNT  = 1950;
    localparam int QUIET_TAIL  = 250;   // last items go without gaps
    // longest correct gap between transfers: a read holds busy for a whole rotation,
    // then comes a sender gap; the end wait is added on top
    localparam int STALL_LIMIT = 1000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       i_op;
    logic signed [WEIGHT_W-1:0] i_new_weight;
    logic [TAG_W-1:0]           i_new_tag;
    logic [RANK_W-1:0]          i_rank;
    logic                       o_busy;
    logic                       o_valid;
    logic signed [WEIGHT_W-1:0] o_out_weight;
    logic [TAG_W-1:0]           o_out_tag;

    int mismatch_count;
    int reads_due;
    int quiet_cycles = 0;

    // free-running clock, period 8
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    streaming_top_k_select_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_op         (i_op),
        .i_new_weight (i_new_weight),
        .i_new_tag    (i_new_tag),
        .i_rank       (i_rank),
        .o_valid      (o_valid),
        .o_out_weight (o_out_weight),
        .o_out_tag    (o_out_tag)
    );

    // watches both channels, keeps its own copy of the list and compares
    stks_rank_checker u_rank_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_op             (i_op),
        .i_new_weight     (i_new_weight),
        .i_new_tag        (i_new_tag),
        .i_rank           (i_rank),
        .i_valid          (o_valid),
        .i_out_weight     (o_out_weight),
        .i_out_tag        (o_out_tag),
        .o_mismatch_count (mismatch_count),
        .o_reads_due      (reads_due)
    );

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // weights mostly in a narrow band so ties are common and the list fills,
    // with full-range values, extremes and negatives mixed in
    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return $urandom_range(0, 400);
        end else if (roll < 65) begin
            return $urandom_range(401, 100000);
        end else if (roll < 80) begin
            return $urandom;
        end else if (roll < 90) begin
            case ($urandom_range(0, 5))
                0: return 32'sh7fffffff;
                1: return 32'sh7ffffffe;
                2: return 32'sh80000000;
                3: return -1;
                4: return 0;
                default: return 1;
            endcase
        end
        return -int'($urandom_range(1, 50));
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return '0;
        end else if (roll < 20) begin
            return '1;
        end
        return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
    endfunction

    // mostly in range, some near the top, some past the end
    function automatic logic [RANK_W-1:0] pick_rank();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return RANK_W'($urandom_range(0, KEEP - 1));
        end else if (roll < 85) begin
            return RANK_W'($urandom_range(0, 4));
        end
        return RANK_W'($urandom_range(KEEP, (1 << RANK_W) - 1));
    endfunction

    // hold the command until the edge that takes it
    task automatic issue_item(input logic op, input logic signed [WEIGHT_W-1:0] w,
                              input logic [TAG_W-1:0] t, input logic [RANK_W-1:0] r);
        i_start      <= 1'b1;
        i_op         <= op;
        i_new_weight <= w;
        i_new_tag    <= t;
        i_rank       <= r;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    // sender gap, with junk on the fields that must be ignored
    task automatic idle_for(input int cycles);
        i_start      <= 1'b0;
        i_op         <= 1'($urandom);
        i_new_weight <= pick_weight();
        i_new_tag    <= pick_tag();
        i_rank       <= pick_rank();
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_op         <= OP_INSERT;
        i_new_weight <= '0;
        i_new_tag    <= '0;
        i_rank       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, saturating ranks, ignored and tied inserts
        issue_item(OP_READ,   0, 0, 0);
        issue_item(OP_READ,   0, 0, 7'(KEEP - 1));
        issue_item(OP_READ,   0, 0, 7'h7f);
        issue_item(OP_INSERT, -1, 20'h00001, 0);              // below lightest, dropped
        issue_item(OP_INSERT, 32'sh80000000, 20'h00002, 0);   // most negative, dropped
        issue_item(OP_INSERT, 0, 20'hfffff, 7'h7f);           // equal to lightest, taken
        issue_item(OP_READ,   0, 0, 0);
        issue_item(OP_READ,   0, 0, 7'(KEEP - 1));
        issue_item(OP_INSERT, 32'sh7fffffff, 20'h00003, 0);   // largest weight
        issue_item(OP_INSERT, 32'sh7fffffff, 20'h00004, 0);   // tie at the top
        issue_item(OP_READ,   0, 0, 0);
        issue_item(OP_READ,   0, 0, 1);
        issue_item(OP_INSERT, 1, 20'h00005, 0);
        issue_item(OP_INSERT, 0, 20'h00006, 0);
        issue_item(OP_INSERT, 32'sh7ffffffe, 20'h55555, 0);
        issue_item(OP_READ,   0, 0, 2);
        issue_item(OP_READ,   0, 0, 3);
        issue_item(OP_READ,   0, 0, 4);
        issue_item(OP_READ,   0, 0, 5);
        issue_item(OP_READ,   0, 0, 7'(KEEP));
        issue_item(OP_READ,   0, 0, 7'h40);

        // random: mostly inserts, a quarter reads, gaps in bursts until the tail
        for (int n = 0; n < ITEM_COUNT - 21; n++) begin
            if (n < ITEM_COUNT - 21 - QUIET_TAIL && $urandom_range(0, 99) < 30) begin
                idle_for($urandom_range(1, 6));
            end
            if ($urandom_range(0, 99) < 25) begin
                issue_item(OP_READ, pick_weight(), pick_tag(), pick_rank());
            end else begin
                issue_item(OP_INSERT, pick_weight(), pick_tag(), pick_rank());
            end
        end
        i_start <= 1'b0;

        // drain outstanding reads, then let a full rotation pass for stray strobes
        while (reads_due != 0) begin
            @(posedge i_clk);
        end
        repeat (KEEP + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
